// ===== rtl/gsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared widths, reset values and register indexes for the gradient
// sharpness metric unit.
// ----------------------------------------------------------------------------
package gsm_pkg;

  // field widths
  localparam int PixW    = 8;   // pixel word
  localparam int CfgW    = 13;  // geometry register
  localparam int CfgIdxW = 2;   // register index
  localparam int OutW    = 14;  // sharpness word, Q.4
  localparam int FracW   = 4;
  localparam int SumW    = 38;  // score accumulator

  // geometry arithmetic; wide enough for the largest legal max dimension
  localparam int DimExtW = 15;
  localparam int ProdW   = 2 * DimExtW;
  localparam int MinDim  = 2;

  // gradient magnitude: sqrt((dx^2 + dy^2) << 8), 26-bit radicand
  localparam int SqW     = 2 * PixW + 1;
  localparam int RadW    = 26;
  localparam int RootW   = RadW / 2;
  localparam int DxySumW = PixW + 1;

  // defaults
  localparam int MaxWidthDef  = 4096;
  localparam int MaxHeightDef = 4096;
  localparam logic [CfgW-1:0] WidthRst  = CfgW'(640);
  localparam logic [CfgW-1:0] HeightRst = CfgW'(480);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROOT,
    ST_MUL,
    ST_DIV,
    ST_DIVW
  } gsm_state_e;

endpackage

`default_nettype wire

// ===== rtl/gsm_line_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_line_mem
// Line store: one write port, two read ports, registered read data.
// A read at the written address returns the old entry.
// ----------------------------------------------------------------------------
module gsm_line_mem #(
  parameter int MaxWidth = gsm_pkg::MaxWidthDef,
  localparam int AddrW   = $clog2(MaxWidth)
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire  [AddrW-1:0]         waddr_i,
  input  wire  [gsm_pkg::PixW-1:0] wdata_i,
  input  wire  [AddrW-1:0]         raddr0_i,
  input  wire  [AddrW-1:0]         raddr1_i,
  output logic [gsm_pkg::PixW-1:0] rdata0_o,
  output logic [gsm_pkg::PixW-1:0] rdata1_o
);

  logic [gsm_pkg::PixW-1:0] mem [MaxWidth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gsm_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_sqrt
// Bit-serial integer square root, one root bit per cycle, rounded down.
// ----------------------------------------------------------------------------
module gsm_sqrt (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire  [gsm_pkg::RadW-1:0]  radicand_i,
  output logic                      busy_o,
  output logic [gsm_pkg::RootW-1:0] root_o
);

  localparam int RootW = gsm_pkg::RootW;
  localparam int RadW  = gsm_pkg::RadW;
  localparam int CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]    rad_q, rad_d;
  logic [RootW+1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;

  logic [RootW+3:0]   shifted;
  logic [RootW+3:0]   trial;

  always_comb begin
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q, rad_q[RadW-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = (RootW + 2)'(shifted - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = (RootW + 2)'(shifted);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== rtl/gsm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_div
// Restoring divider for the frame mean, one quotient bit per cycle.
// Quotients past the output range are caught up front and saturate.
// ----------------------------------------------------------------------------
module gsm_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [gsm_pkg::SumW-1:0] dividend_i,
  input  wire  [gsm_pkg::ProdW-1:0] divisor_i,
  output logic                     busy_o,
  output logic [gsm_pkg::OutW-1:0] quotient_o
);

  localparam int SumW  = gsm_pkg::SumW;
  localparam int ProdW = gsm_pkg::ProdW;
  localparam int OutW  = gsm_pkg::OutW;
  localparam int CntW  = $clog2(OutW + 1);

  logic [ProdW-1:0] rem_q, rem_d;
  logic [OutW-1:0]  low_q, low_d;
  logic [OutW-1:0]  quo_q, quo_d;
  logic [ProdW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [ProdW-1:0] top_part;
  logic [ProdW:0]   shifted;

  always_comb begin
    rem_d    = rem_q;
    low_d    = low_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    top_part = ProdW'(dividend_i[SumW-1:OutW]);
    shifted  = {rem_q, low_q[OutW-1]};
    if (start_i) begin
      rem_d = top_part;
      low_d = dividend_i[OutW-1:0];
      dvs_d = divisor_i;
      quo_d = '0;
      cnt_d = CntW'(OutW);
      if (top_part >= divisor_i) begin
        // mean at or beyond full scale
        quo_d  = '1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      low_d = {low_q[OutW-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = ProdW'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[OutW-2:0], 1'b1};
      end else begin
        rem_d = ProdW'(shifted);
        quo_d = {quo_q[OutW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/gradient_sharpness_metric_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_sharpness_metric_unit
// Frame sharpness meter: mean of sqrt(dx^2+dy^2)+|dx|+|dy| over a frame.
// ----------------------------------------------------------------------------
// Usage: feed one grayscale frame per frame_height x frame_width words in
// raster order. For every pixel with a right and a lower neighbor, the block
// sums floor(16*sqrt(dx^2+dy^2)) + 16*(|dx|+|dy|), dx and dy taken against
// the right and lower neighbor. After the last pixel of the frame one word
// comes out: the sum divided by width*height, unsigned Q.4, saturating at
// 16383. Geometry outside 2..MaxWidth / 2..MaxHeight is clamped. Flow:
// pixels in the first row or the last column pass straight through; every
// other pixel holds off the stream while the line store read, the bit-serial
// square root (13 root bits, one per cycle) and the accumulate run in turn.
// The frame's last pixel is followed by the width*height product and the
// 14-step divider before the result is loaded. The result sits in an output
// register, so the next frame may start while it waits to be taken. No
// clearing pass after reset: the line store is always written before read.
// ----------------------------------------------------------------------------
module gradient_sharpness_metric_unit #(
  parameter int MaxWidth  = gsm_pkg::MaxWidthDef,
  parameter int MaxHeight = gsm_pkg::MaxHeightDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration writes
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [gsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire  [gsm_pkg::CfgW-1:0]    cfg_data_i,
  // pixel stream
  input  wire                         pixel_valid_i,
  output logic                        pixel_ready_o,
  input  wire  [gsm_pkg::PixW-1:0]    pixel_i,
  // result
  output logic                        sharpness_valid_o,
  input  wire                         sharpness_ready_i,
  output logic [gsm_pkg::OutW-1:0]    sharpness_o
);

  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int PixW    = gsm_pkg::PixW;
  localparam int CfgW    = gsm_pkg::CfgW;
  localparam int DimExtW = gsm_pkg::DimExtW;
  localparam int ProdW   = gsm_pkg::ProdW;
  localparam int SumW    = gsm_pkg::SumW;
  localparam int OutW    = gsm_pkg::OutW;
  localparam int FracW   = gsm_pkg::FracW;
  localparam int SqW     = gsm_pkg::SqW;
  localparam int RadW    = gsm_pkg::RadW;
  localparam int RootW   = gsm_pkg::RootW;
  localparam int DxyW    = gsm_pkg::DxySumW;

  // --------------------------------------------------------------------------
  // Geometry registers
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gsm_pkg::WidthRst;
      height_q <= gsm_pkg::HeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsm_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        gsm_pkg::RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp to 2..max
  logic [DimExtW-1:0] w_ext, h_ext, w_clamp, h_clamp;
  logic [ColW-1:0]    w_last;
  logic [RowW-1:0]    h_last;

  always_comb begin
    w_ext = DimExtW'(width_q);
    h_ext = DimExtW'(height_q);
    if (w_ext < DimExtW'(gsm_pkg::MinDim)) begin
      w_clamp = DimExtW'(gsm_pkg::MinDim);
    end else if (w_ext > DimExtW'(MaxWidth)) begin
      w_clamp = DimExtW'(MaxWidth);
    end else begin
      w_clamp = w_ext;
    end
    if (h_ext < DimExtW'(gsm_pkg::MinDim)) begin
      h_clamp = DimExtW'(gsm_pkg::MinDim);
    end else if (h_ext > DimExtW'(MaxHeight)) begin
      h_clamp = DimExtW'(MaxHeight);
    end else begin
      h_clamp = h_ext;
    end
    w_last = ColW'(w_clamp - DimExtW'(1));
    h_last = RowW'(h_clamp - DimExtW'(1));
  end

  // --------------------------------------------------------------------------
  // Position counters, clamped against the current geometry
  // --------------------------------------------------------------------------
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_cur;
  logic [RowW-1:0] row_cur;
  logic            last_col, last_row, do_score;

  assign col_cur  = (col_q > w_last) ? w_last : col_q;
  assign row_cur  = (row_q > h_last) ? h_last : row_q;
  assign last_col = (col_cur == w_last);
  assign last_row = (row_cur == h_last);
  assign do_score = (row_cur != '0) && !last_col;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  gsm_pkg::gsm_state_e state_q, state_d;

  logic pix_acc;
  logic sqrt_start, sqrt_busy;
  logic div_start, div_busy;
  logic out_free;
  logic out_load;
  logic sum_add, sum_clr;
  logic wh_load, dxy_load;

  assign pix_acc  = pixel_valid_i && pixel_ready_o;
  assign out_free = !sharpness_valid_o || sharpness_ready_i;

  always_comb begin
    state_d       = state_q;
    pixel_ready_o = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    sum_add       = 1'b0;
    sum_clr       = 1'b0;
    wh_load       = 1'b0;
    dxy_load      = 1'b0;
    unique case (state_q)
      gsm_pkg::ST_IDLE: begin
        pixel_ready_o = 1'b1;
        if (pixel_valid_i) begin
          if (do_score) begin
            state_d = gsm_pkg::ST_READ;
          end else if (last_col && last_row) begin
            state_d = gsm_pkg::ST_MUL;
          end
        end
      end
      gsm_pkg::ST_READ: begin
        // line store words are in; square and start the root
        sqrt_start = 1'b1;
        dxy_load   = 1'b1;
        state_d    = gsm_pkg::ST_ROOT;
      end
      gsm_pkg::ST_ROOT: begin
        if (!sqrt_busy) begin
          sum_add = 1'b1;
          state_d = gsm_pkg::ST_IDLE;
        end
      end
      gsm_pkg::ST_MUL: begin
        wh_load = 1'b1;
        state_d = gsm_pkg::ST_DIV;
      end
      gsm_pkg::ST_DIV: begin
        div_start = 1'b1;
        sum_clr   = 1'b1;
        state_d   = gsm_pkg::ST_DIVW;
      end
      gsm_pkg::ST_DIVW: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          state_d  = gsm_pkg::ST_IDLE;
        end
      end
      default: state_d = gsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // counters advance on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_cur + RowW'(1);
      end else begin
        col_q <= col_cur + ColW'(1);
        row_q <= row_cur;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line store: read pixel above and above-right, write the new pixel
  // --------------------------------------------------------------------------
  logic [PixW-1:0] above, above_right;
  logic [PixW-1:0] pix_q;

  gsm_line_mem #(
    .MaxWidth (MaxWidth)
  ) u_line_mem (
    .clk_i    (clk_i),
    .en_i     (pix_acc),
    .waddr_i  (col_cur),
    .wdata_i  (pixel_i),
    .raddr0_i (col_cur),
    .raddr1_i (col_cur + ColW'(1)),
    .rdata0_o (above),
    .rdata1_o (above_right)
  );

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      pix_q <= pixel_i;
    end
  end

  // --------------------------------------------------------------------------
  // Gradient: |dx|, |dy|, squares, root
  // --------------------------------------------------------------------------
  logic [PixW-1:0]  dx, dy;
  logic [SqW-1:0]   sq_sum;
  logic [RadW-1:0]  radicand;
  logic [DxyW-1:0]  dxy_q;
  logic [RootW-1:0] root;

  always_comb begin
    dx       = (above_right > above) ? above_right - above : above - above_right;
    dy       = (pix_q > above) ? pix_q - above : above - pix_q;
    sq_sum   = SqW'(dx) * SqW'(dx) + SqW'(dy) * SqW'(dy);
    radicand = RadW'({sq_sum, 8'b0});
  end

  always_ff @(posedge clk_i) begin
    if (dxy_load) begin
      dxy_q <= DxyW'(dx) + DxyW'(dy);
    end
  end

  gsm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // --------------------------------------------------------------------------
  // Accumulator, frame area, divider
  // --------------------------------------------------------------------------
  logic [SumW-1:0]  sum_q;
  logic [ProdW-1:0] wh_q;
  logic [OutW-1:0]  mean;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (sum_clr) begin
      sum_q <= '0;
    end else if (sum_add) begin
      sum_q <= sum_q + SumW'(root) + SumW'({dxy_q, FracW'(0)});
    end
  end

  always_ff @(posedge clk_i) begin
    if (wh_load) begin
      wh_q <= ProdW'(w_clamp) * ProdW'(h_clamp);
    end
  end

  gsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (wh_q),
    .busy_o     (div_busy),
    .quotient_o (mean)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic            out_valid_q;
  logic [OutW-1:0] out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (sharpness_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= mean;
    end
  end

  assign sharpness_valid_o = out_valid_q;
  assign sharpness_o       = out_word_q;

endmodule

`default_nettype wire
